FILE: hdl/tasc_pkg.sv
package tasc_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int EXT_W   = TERM_W + 2;
    localparam int SPEED_W = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TILT_RATE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RATE_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_GAIN   = 2'd2;

    // |tilt| < 0.05  <=>  20*|tilt| < 1.0  <=>  |tilt| < ceil(65536/20)
    localparam int UPRIGHT_NUM   = 20;
    localparam int ONE_Q16       = 1 << FRAC_W;
    localparam logic [DATA_W-1:0] UPRIGHT_LIMIT =
        DATA_W'((ONE_Q16 + UPRIGHT_NUM - 1) / UPRIGHT_NUM);

    localparam int SPEED_LIMIT = 15 * ONE_Q16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MID,
        S_MUL_B,
        S_TILT,
        S_WHEEL,
        S_SPEED
    } t_state;

    function automatic logic [DATA_W-1:0] abs_val(input logic [DATA_W-1:0] x);
        abs_val = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
    endfunction

    // saturate a sign-extended sum to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat_acc(input logic [EXT_W-1:0] x);
        logic [DATA_W-1:0] res;
        res = x[DATA_W-1:0];
        if (x[EXT_W-1]) begin
            if (!(&x[EXT_W-1:DATA_W-1])) begin
                res = {1'b1, {(DATA_W-1){1'b0}}};
            end
        end else begin
            if (|x[EXT_W-1:DATA_W-1]) begin
                res = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
        sat_acc = res;
    endfunction

endpackage

FILE: hdl/tasc_serial_mul.sv
module tasc_serial_mul #(
    parameter int WIDTH = tasc_pkg::DATA_W
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_run,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [2*WIDTH-1:0] o_product
);

    // unsigned shift-add: one multiplier bit retired per cycle while i_run is high
    logic [WIDTH-1:0]   r_a;
    logic [2*WIDTH-1:0] r_prod;
    logic [WIDTH:0]     w_sum;
    logic [2*WIDTH-1:0] n_prod;

    assign w_sum  = {1'b0, r_prod[2*WIDTH-1:WIDTH]} +
                    (r_prod[0] ? {1'b0, r_a} : {(WIDTH+1){1'b0}});
    assign n_prod = {w_sum, r_prod[WIDTH-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a    <= i_a;
            r_prod <= {{WIDTH{1'b0}}, i_b};
        end else if (i_run) begin
            r_prod <= n_prod;
        end
    end

    assign o_product = r_prod;

endmodule

FILE: hdl/tilt_acceleration_speed_control_unit.sv
// Tilt-driven acceleration and wheel speed controller. Each input transfer is one
// control tick (Q16.16 tilt, tilt rate, wheel rate, emergency flag) and yields one
// output transfer with the clamped speed command and the acceleration accumulator.
// The products are formed by bit-serial shift-add multipliers, one multiplier bit
// per cycle, in two passes (tilt*rate, recovery threshold and wheel term in
// parallel, then the gain on the saturated tilt product), then the tilt, wheel and
// speed updates. An emergency tick goes straight to the speed update. A new tick
// is taken while the previous result still waits in the output register. Gains
// are written through the plain write port (0: tilt rate gain, 1: wheel rate gain,
// 2: recovery gain) by the user only while idle; the block does not enforce it.
module tilt_acceleration_speed_control_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tasc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tasc_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tasc_pkg::DATA_W-1:0]   i_tilt_angle,
    input  logic signed [tasc_pkg::DATA_W-1:0]   i_tilt_rate,
    input  logic signed [tasc_pkg::DATA_W-1:0]   i_wheel_rate,
    input  logic                                 i_emergency,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tasc_pkg::SPEED_W-1:0]  o_speed_command,
    output logic signed [tasc_pkg::DATA_W-1:0]   o_accel_target
);

    localparam int DW  = tasc_pkg::DATA_W;
    localparam int PW  = tasc_pkg::PROD_W;
    localparam int TW  = tasc_pkg::TERM_W;
    localparam int XW  = tasc_pkg::EXT_W;
    localparam int FW  = tasc_pkg::FRAC_W;
    localparam int SW  = tasc_pkg::SPEED_W;
    localparam int CNT_W = $clog2(DW);
    localparam int SUM_W = DW + 1;
    localparam logic signed [SUM_W-1:0] SPEED_MAX = SUM_W'(tasc_pkg::SPEED_LIMIT);
    localparam logic signed [SUM_W-1:0] SPEED_MIN = -SPEED_MAX;

    // configuration
    logic [DW-1:0] r_tilt_rate_gain;
    logic [DW-1:0] r_wheel_rate_gain;
    logic [DW-1:0] r_recovery_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_rate_gain  <= '0;
            r_wheel_rate_gain <= '0;
            r_recovery_gain   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tasc_pkg::CFG_TILT_RATE_GAIN:  r_tilt_rate_gain  <= i_cfg_data;
                tasc_pkg::CFG_WHEEL_RATE_GAIN: r_wheel_rate_gain <= i_cfg_data;
                tasc_pkg::CFG_RECOVERY_GAIN:   r_recovery_gain   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    tasc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;
    logic             w_out_free;
    logic             w_out_load;

    assign o_in_stall = (r_state != tasc_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_out_load = (r_state == tasc_pkg::S_SPEED) && w_out_free;

    // captured tick
    logic [DW-1:0] r_at, r_ar;
    logic          r_tilt_neg, r_tilt_nz, r_rate_nz, r_same, r_wheel_neg, r_emerg;
    logic          r_recover;
    logic [TW-1:0] r_wheel_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tasc_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            tasc_pkg::S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = i_emergency ? tasc_pkg::S_SPEED : tasc_pkg::S_MUL_A;
                end
            end
            tasc_pkg::S_MUL_A: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (&r_cnt) begin
                    n_state = tasc_pkg::S_MID;
                end
            end
            tasc_pkg::S_MID: begin
                n_cnt   = '0;
                n_state = tasc_pkg::S_MUL_B;
            end
            tasc_pkg::S_MUL_B: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (&r_cnt) begin
                    n_state = tasc_pkg::S_TILT;
                end
            end
            tasc_pkg::S_TILT:  n_state = tasc_pkg::S_WHEEL;
            tasc_pkg::S_WHEEL: n_state = tasc_pkg::S_SPEED;
            tasc_pkg::S_SPEED: begin
                if (w_out_free) begin
                    n_state = tasc_pkg::S_IDLE;
                end
            end
            default: n_state = tasc_pkg::S_IDLE;
        endcase
    end

    // multipliers
    logic [DW-1:0] w_in_at, w_in_ar;
    logic [PW-1:0] w_p1, w_p2, w_p3;
    logic [DW-1:0] w_m1_sat;
    logic          w_mul1_load, w_mul1_run, w_mul_a_run;
    logic [DW-1:0] w_mul1_a, w_mul1_b;

    assign w_in_at = tasc_pkg::abs_val(i_tilt_angle);
    assign w_in_ar = tasc_pkg::abs_val(i_tilt_rate);

    // (|tilt|*|rate|) >> 16, saturated to 32 bits unsigned
    assign w_m1_sat = (|w_p1[PW-1:DW+FW]) ? {DW{1'b1}} : w_p1[DW+FW-1:FW];

    assign w_mul1_load = w_accept || (r_state == tasc_pkg::S_MID);
    assign w_mul_a_run = (r_state == tasc_pkg::S_MUL_A);
    assign w_mul1_run  = w_mul_a_run || (r_state == tasc_pkg::S_MUL_B);
    assign w_mul1_a    = (r_state == tasc_pkg::S_MID) ? w_m1_sat : w_in_at;
    assign w_mul1_b    = (r_state == tasc_pkg::S_MID) ?
                         tasc_pkg::abs_val(r_tilt_rate_gain) : w_in_ar;

    tasc_serial_mul #(.WIDTH(DW)) u_mul_tilt (
        .i_clk     (i_clk),
        .i_load    (w_mul1_load),
        .i_run     (w_mul1_run),
        .i_a       (w_mul1_a),
        .i_b       (w_mul1_b),
        .o_product (w_p1)
    );

    tasc_serial_mul #(.WIDTH(DW)) u_mul_recover (
        .i_clk     (i_clk),
        .i_load    (w_accept),
        .i_run     (w_mul_a_run),
        .i_a       (tasc_pkg::abs_val(r_recovery_gain)),
        .i_b       (w_in_at),
        .o_product (w_p2)
    );

    tasc_serial_mul #(.WIDTH(DW)) u_mul_wheel (
        .i_clk     (i_clk),
        .i_load    (w_accept),
        .i_run     (w_mul_a_run),
        .i_a       (tasc_pkg::abs_val(i_wheel_rate)),
        .i_b       (tasc_pkg::abs_val(r_wheel_rate_gain)),
        .o_product (w_p3)
    );

    // datapath
    logic [PW-1:0] w_wheel_signed;
    logic [PW-1:0] w_rate_shift;
    logic [XW-1:0] w_acc_ext, w_mod_ext, w_tilt_sum, w_wheel_sum;
    logic signed [SUM_W-1:0] w_speed_sum, w_speed_clamp;
    logic [DW-1:0] r_accel_accum;
    logic [SW-1:0] r_speed_target;

    assign w_wheel_signed = r_wheel_neg ? (~w_p3 + PW'(1)) : w_p3;
    assign w_rate_shift   = {{(PW-DW-FW){1'b0}}, r_ar, {FW{1'b0}}};

    assign w_acc_ext   = {{(XW-DW){r_accel_accum[DW-1]}}, r_accel_accum};
    assign w_mod_ext   = {{(XW-TW){1'b0}}, w_p1[PW-1:FW]};
    assign w_tilt_sum  = r_tilt_neg ? (w_acc_ext - w_mod_ext) : (w_acc_ext + w_mod_ext);
    assign w_wheel_sum = w_acc_ext + {{(XW-TW){r_wheel_term[TW-1]}}, r_wheel_term};

    assign w_speed_sum = $signed({{(SUM_W-SW){r_speed_target[SW-1]}}, r_speed_target}) +
                         $signed({r_accel_accum[DW-1], r_accel_accum});

    always_comb begin
        priority if (w_speed_sum > SPEED_MAX) begin
            w_speed_clamp = SPEED_MAX;
        end else if (w_speed_sum < SPEED_MIN) begin
            w_speed_clamp = SPEED_MIN;
        end else begin
            w_speed_clamp = w_speed_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_at        <= w_in_at;
            r_ar        <= w_in_ar;
            r_tilt_neg  <= i_tilt_angle[DW-1];
            r_tilt_nz   <= |i_tilt_angle;
            r_rate_nz   <= |i_tilt_rate;
            r_same      <= (i_tilt_angle[DW-1] == i_tilt_rate[DW-1]);
            r_wheel_neg <= i_wheel_rate[DW-1] ^ r_wheel_rate_gain[DW-1];
            r_emerg     <= i_emergency;
        end
        if (r_state == tasc_pkg::S_MID) begin
            // a non-positive recovery gain makes any nonzero rate count as recovering
            r_recover    <= r_recovery_gain[DW-1] || !(|r_recovery_gain) ||
                            (w_rate_shift > w_p2);
            r_wheel_term <= w_wheel_signed[PW-1:FW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_accum  <= '0;
            r_speed_target <= '0;
        end else begin
            unique case (r_state)
                tasc_pkg::S_TILT: begin
                    if (r_tilt_nz && r_rate_nz) begin
                        if (!r_same && r_recover) begin
                            r_accel_accum <= '0;
                        end else begin
                            r_accel_accum <= tasc_pkg::sat_acc(w_tilt_sum);
                        end
                    end
                end
                tasc_pkg::S_WHEEL: begin
                    if (r_at < tasc_pkg::UPRIGHT_LIMIT) begin
                        r_accel_accum <= tasc_pkg::sat_acc(w_wheel_sum);
                    end
                end
                tasc_pkg::S_SPEED: begin
                    if (w_out_free) begin
                        if (r_emerg) begin
                            r_accel_accum  <= '0;
                            r_speed_target <= '0;
                        end else begin
                            r_speed_target <= w_speed_clamp[SW-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    logic          r_out_valid;
    logic [SW-1:0] r_speed_cmd;
    logic [DW-1:0] r_accel_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_emerg) begin
                r_speed_cmd <= '0;
                r_accel_tgt <= '0;
            end else begin
                r_speed_cmd <= w_speed_clamp[SW-1:0];
                r_accel_tgt <= r_accel_accum;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_command = r_speed_cmd;
    assign o_accel_target  = r_accel_tgt;

endmodule
